// ===== sv/logical_interrupt_controller_macros.svh =====
// Assertion macros for the logical interrupt controller event queue (lic_evq)
`ifndef LOGICAL_INTERRUPT_CONTROLLER_MACROS_SVH
`define LOGICAL_INTERRUPT_CONTROLLER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define LIC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define LIC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/lic_pkg.sv =====
// Shared types and constants for the logical interrupt controller
`timescale 1ns / 1ps

package lic_pkg;

  // Route table limits and configuration port shape
  localparam int MAX_ROUTES    = 4;
  localparam int ROUTE_COUNT_D = 4;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_W         = 6;

  // Level-one serviceable CPU interrupts
  localparam logic [31:0] L1_MASK = 32'h0006_37FF;

  // Fixed CPU interrupt numbers
  localparam logic [4:0] TIMER_INT    = 5'd6;
  localparam logic [4:0] DOORBELL_INT = 5'd7;

  // Operation codes
  localparam logic [2:0] OP_MASK     = 3'd0;
  localparam logic [2:0] OP_UNMASK   = 3'd1;
  localparam logic [2:0] OP_INJECT   = 3'd2;
  localparam logic [2:0] OP_CLEAR    = 3'd3;
  localparam logic [2:0] OP_DISPATCH = 3'd4;
  localparam logic [2:0] OP_TMR_EN   = 3'd5;
  localparam logic [2:0] OP_TMR_DIS  = 3'd6;

  // Event kinds
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_TIMER  = 2'd1;
  localparam logic [1:0] KIND_LINE   = 2'd2;
  localparam logic [1:0] KIND_DEVICE = 2'd3;

  // One result event
  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] number;
    logic       last;
  } event_t;

endpackage

// ===== sv/logical_interrupt_controller.sv =====
// A request is held in the request register and executes once the event slots
// are empty; a dispatch's results are loaded into the event slots and then
// presented through the output register. Throughput: one request per cycle
// while no events are queued; a dispatch holds the following request until its
// event slots drain into the output register, one per cycle while not stalled.
// Reset (synchronous, rst_n low): all lines masked, routes unbound, nothing pending or queued.
`timescale 1ns / 1ps

module logical_interrupt_controller #(
  parameter int ROUTE_COUNT = lic_pkg::ROUTE_COUNT_D
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    in_operation,
  input  logic [4:0]                    in_line,
  input  logic [31:0]                   in_raw_status,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_event_kind,
  output logic [4:0]                    out_event_number,
  output logic                          out_last,
  input  logic                          cfg_we,
  input  logic [lic_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lic_pkg::CFG_W-1:0]     cfg_data
);

  localparam int NSLOT = ROUTE_COUNT + 2;

  logic [2:0]  op_r;
  logic [4:0]  line_r;
  logic [31:0] raw_r;
  logic        s1_vld_r, s1_vld_nxt;
  logic        q_empty;
  logic        fire;
  logic        accept;

  logic                        ld;
  lic_pkg::event_t [NSLOT-1:0] ld_ev;
  logic [NSLOT-1:0]            ld_vld;
  lic_pkg::event_t             out_ev;

  // Execute the held request once the event slots are free
  assign fire     = s1_vld_r && q_empty;
  assign in_stall = s1_vld_r && !q_empty;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (accept) begin
      s1_vld_nxt = 1'b1;
    end else if (fire) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  // Capture request payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_operation;
      line_r <= in_line;
      raw_r  <= in_raw_status;
    end
  end

  lic_core #(
    .ROUTE_COUNT (ROUTE_COUNT),
    .NSLOT       (NSLOT)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .op        (op_r),
    .line      (line_r),
    .raw       (raw_r),
    .ld        (ld),
    .ld_ev     (ld_ev),
    .ld_vld    (ld_vld)
  );

  lic_evq #(
    .NSLOT (NSLOT)
  ) u_evq (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld        (ld),
    .ld_ev     (ld_ev),
    .ld_vld    (ld_vld),
    .empty     (q_empty),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_ev    (out_ev)
  );

  assign out_event_kind   = out_ev.kind;
  assign out_event_number = out_ev.number;
  assign out_last         = out_ev.last;

endmodule

// ===== sv/lic_core.sv =====
// Interrupt state, route table and single-pass request execution
`timescale 1ns / 1ps

module lic_core #(
  parameter int ROUTE_COUNT = lic_pkg::ROUTE_COUNT_D,
  parameter int NSLOT       = ROUTE_COUNT + 2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [lic_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lic_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                fire,
  input  logic [2:0]                          op,
  input  logic [4:0]                          line,
  input  logic [31:0]                         raw,
  output logic                                ld,
  output lic_pkg::event_t [NSLOT-1:0]         ld_ev,
  output logic [NSLOT-1:0]                    ld_vld
);

  logic [31:0] masked_r, masked_nxt;
  logic [31:0] pending_r, pending_nxt;
  logic [5:0]  inj_r, inj_nxt;
  logic [31:0] cpu_en_r, cpu_en_nxt;
  logic        door_r, door_nxt;
  logic [5:0]  route_cpu_r [ROUTE_COUNT];
  logic [5:0]  route_line_r [ROUTE_COUNT];

  // Look up the CPU interrupt routed to the request line; first route wins
  logic       found;
  logic       ci_ok;
  logic [4:0] ci_num;

  always_comb begin
    found  = 1'b0;
    ci_ok  = 1'b0;
    ci_num = '0;
    for (int i = 0; i < ROUTE_COUNT; i++) begin
      if (!found && !route_line_r[i][5] && route_line_r[i][4:0] == line) begin
        found  = 1'b1;
        ci_ok  = !route_cpu_r[i][5];
        ci_num = route_cpu_r[i][4:0];
      end
    end
  end

  // Build the dispatch event slots from the sampled serviceable set
  logic [31:0]      pend;
  logic [NSLOT-1:0] v;
  logic [NSLOT-1:0] last_v;
  logic             higher;
  logic             dup;
  logic             is_disp;

  always_comb begin
    is_disp = fire && (op == lic_pkg::OP_DISPATCH);
    pend    = (raw | ({31'd0, door_r} << lic_pkg::DOORBELL_INT)) & cpu_en_r & lic_pkg::L1_MASK;
    v       = '0;
    ld_ev   = '0;
    ld_ev[0].kind   = lic_pkg::KIND_TIMER;
    ld_ev[0].number = lic_pkg::TIMER_INT;
    v[0]            = pend[lic_pkg::TIMER_INT];
    ld_ev[1].kind   = lic_pkg::KIND_LINE;
    ld_ev[1].number = inj_r[4:0];
    v[1]            = pend[lic_pkg::DOORBELL_INT] && !inj_r[5];
    for (int i = 0; i < ROUTE_COUNT; i++) begin
      dup = 1'b0;
      for (int j = 0; j < i; j++) begin
        if (!route_cpu_r[j][5] && route_cpu_r[j] == route_cpu_r[i]) begin
          dup = 1'b1;
        end
      end
      ld_ev[i+2].kind   = lic_pkg::KIND_DEVICE;
      ld_ev[i+2].number = route_cpu_r[i][4:0];
      v[i+2]            = !route_cpu_r[i][5] && pend[route_cpu_r[i][4:0]] && !dup;
    end
    // Nothing served: one empty event in the first slot
    if (v == '0) begin
      ld_ev[0].kind   = lic_pkg::KIND_NONE;
      ld_ev[0].number = '0;
      v[0]            = 1'b1;
    end
    // Mark the final valid slot
    higher = 1'b0;
    for (int k = NSLOT - 1; k >= 0; k--) begin
      last_v[k]     = v[k] && !higher;
      ld_ev[k].last = last_v[k];
      higher        = higher | v[k];
    end
    ld     = fire;
    ld_vld = is_disp ? v : '0;
  end

  // Next state for the executing request and configuration writes
  logic [31:0] bit_l;

  always_comb begin
    bit_l       = 32'd1 << line;
    masked_nxt  = masked_r;
    pending_nxt = pending_r;
    inj_nxt     = inj_r;
    cpu_en_nxt  = cpu_en_r;
    door_nxt    = door_r;
    if (fire) begin
      case (op)
        lic_pkg::OP_MASK: begin
          masked_nxt = masked_r | bit_l;
          if (ci_ok) cpu_en_nxt = cpu_en_r & ~(32'd1 << ci_num);
        end
        lic_pkg::OP_UNMASK: begin
          masked_nxt = masked_r & ~bit_l;
          if (ci_ok) cpu_en_nxt = cpu_en_r | (32'd1 << ci_num);
          if ((pending_r & bit_l) != '0) begin
            pending_nxt = pending_r & ~bit_l;
            inj_nxt     = {1'b0, line};
            cpu_en_nxt[lic_pkg::DOORBELL_INT] = 1'b1;
            door_nxt    = 1'b1;
          end
        end
        lic_pkg::OP_INJECT: begin
          if ((masked_r & bit_l) != '0) begin
            pending_nxt = pending_r | bit_l;
          end else begin
            inj_nxt    = {1'b0, line};
            cpu_en_nxt[lic_pkg::DOORBELL_INT] = 1'b1;
            door_nxt   = 1'b1;
          end
        end
        lic_pkg::OP_CLEAR: begin
          pending_nxt = pending_r & ~bit_l;
        end
        lic_pkg::OP_DISPATCH: begin
          if (pend[lic_pkg::TIMER_INT]) cpu_en_nxt[lic_pkg::TIMER_INT] = 1'b0;
          if (pend[lic_pkg::DOORBELL_INT]) begin
            door_nxt = 1'b0;
            cpu_en_nxt[lic_pkg::DOORBELL_INT] = 1'b0;
            inj_nxt  = 6'h3F;
          end
        end
        lic_pkg::OP_TMR_EN: begin
          cpu_en_nxt[lic_pkg::TIMER_INT] = 1'b1;
        end
        lic_pkg::OP_TMR_DIS: begin
          cpu_en_nxt[lic_pkg::TIMER_INT] = 1'b0;
        end
        default: begin
          cpu_en_nxt = cpu_en_r;
        end
      endcase
    end
    // Binding a CPU interrupt to a route also enables it
    if (cfg_we && !cfg_index[0] && !cfg_data[5]) begin
      for (int i = 0; i < ROUTE_COUNT; i++) begin
        if (cfg_index[2:1] == 2'(i)) cpu_en_nxt[cfg_data[4:0]] = 1'b1;
      end
    end
  end

  // Hold interrupt state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      masked_r  <= '1;
      pending_r <= '0;
      inj_r     <= 6'h3F;
      cpu_en_r  <= '0;
      door_r    <= 1'b0;
    end else begin
      masked_r  <= masked_nxt;
      pending_r <= pending_nxt;
      inj_r     <= inj_nxt;
      cpu_en_r  <= cpu_en_nxt;
      door_r    <= door_nxt;
    end
  end

  // Route registers; indexes past the route count drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ROUTE_COUNT; i++) begin
        route_cpu_r[i]  <= 6'h3F;
        route_line_r[i] <= 6'h3F;
      end
    end else if (cfg_we) begin
      for (int i = 0; i < ROUTE_COUNT; i++) begin
        if (cfg_index[2:1] == 2'(i)) begin
          if (cfg_index[0]) route_line_r[i] <= cfg_data;
          else              route_cpu_r[i]  <= cfg_data;
        end
      end
    end
  end

endmodule

// ===== sv/lic_evq.sv =====
// Event slots of one dispatch drained in order through the output register
`timescale 1ns / 1ps
`include "logical_interrupt_controller_macros.svh"

module lic_evq #(
  parameter int NSLOT = lic_pkg::ROUTE_COUNT_D + 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          ld,
  input  lic_pkg::event_t [NSLOT-1:0]   ld_ev,
  input  logic [NSLOT-1:0]              ld_vld,
  output logic                          empty,
  output logic                          out_valid,
  input  logic                          out_stall,
  output lic_pkg::event_t               out_ev
);

  localparam int SEL_W = $clog2(NSLOT);

  lic_pkg::event_t [NSLOT-1:0] ev_r;
  logic [NSLOT-1:0]            vld_r, vld_nxt;
  lic_pkg::event_t             out_ev_r;
  logic                        out_vld_r, out_vld_nxt;
  logic [SEL_W-1:0]            sel;
  logic                        pop;
  logic [NSLOT-1:0]            last_v;

  // Pick the lowest occupied slot
  always_comb begin
    sel = '0;
    for (int k = NSLOT - 1; k >= 0; k--) begin
      if (vld_r[k]) sel = SEL_W'(k);
    end
  end

  assign empty = (vld_r == '0);
  assign pop   = !empty && (!out_vld_r || !out_stall);

  // Advance slots and output register
  always_comb begin
    vld_nxt = vld_r;
    if (ld) begin
      vld_nxt = ld_vld;
    end else if (pop) begin
      vld_nxt[sel] = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (pop) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      vld_r     <= vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld)  ev_r     <= ld_ev;
    if (pop) out_ev_r <= ev_r[sel];
  end

  assign out_valid = out_vld_r;
  assign out_ev    = out_ev_r;

  always_comb begin
    for (int k = 0; k < NSLOT; k++) begin
      last_v[k] = ld_ev[k].last && ld_vld[k];
    end
  end

  `LIC_ASSERT_SAME(a_load_when_empty, ld, vld_r == '0, "event slots loaded while occupied")
  `LIC_ASSERT_SAME(a_one_last, ld && (ld_vld != '0), $countones(last_v) == 1, "dispatch without single last")
  `LIC_ASSERT_NEXT(a_last_drains, pop && ev_r[sel].last, vld_r == '0, "slots left after last event")

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the logical interrupt controller
`timescale 1ns / 1ps

module tb_top;

  localparam int          ROUTES        = lic_pkg::ROUTE_COUNT_D;
  localparam logic [2:0]  OP_RESERVED   = 3'd7;
  localparam logic        REG_SEL_CPU   = 1'b0;
  localparam logic        REG_SEL_LINE  = 1'b1;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          DRAIN_LIMIT   = 50000;
  localparam int          MAX_REPORTS   = 10;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [2:0]                    in_operation;
  logic [4:0]                    in_line;
  logic [31:0]                   in_raw_status;
  logic                          out_valid;
  logic                          out_stall;
  logic [1:0]                    out_event_kind;
  logic [4:0]                    out_event_number;
  logic                          out_last;
  logic                          cfg_we;
  logic [lic_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lic_pkg::CFG_W-1:0]     cfg_data;

  // Controller state as seen by software
  logic [31:0]       line_masked;
  logic [31:0]       line_pending;
  logic [31:0]       cpu_enable;
  logic              doorbell;
  logic signed [5:0] injected;
  logic signed [5:0] route_cpu [ROUTES];
  logic signed [5:0] route_line [ROUTES];

  lic_pkg::event_t expected_events[$];
  int              mismatches;
  int              send_idle_pct;
  int              stall_pct;
  int              hold_len;
  bit              hold_req;

  logical_interrupt_controller u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_line          (in_line),
    .in_raw_status    (in_raw_status),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_kind   (out_event_kind),
    .out_event_number (out_event_number),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Clear the controller state to its reset values
  function automatic void reset_state();
    for (int r = 0; r < ROUTES; r++) begin
      route_cpu[r]  = -6'sd1;
      route_line[r] = -6'sd1;
    end
    line_masked  = '1;
    line_pending = '0;
    injected     = -6'sd1;
    cpu_enable   = '0;
    doorbell     = 1'b0;
  endfunction

  // First route naming the line decides its CPU interrupt
  function automatic logic signed [5:0] routed_cpu(input logic [4:0] ln);
    for (int r = 0; r < ROUTES; r++) begin
      if (route_line[r] >= 0 && route_line[r][4:0] == ln) return route_cpu[r];
    end
    return -6'sd1;
  endfunction

  function automatic void ring_doorbell(input logic [4:0] ln);
    injected                          = signed'({1'b0, ln});
    cpu_enable[lic_pkg::DOORBELL_INT] = 1'b1;
    doorbell                          = 1'b1;
  endfunction

  // Apply a route register write
  function automatic void apply_route_reg(input logic [lic_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [lic_pkg::CFG_W-1:0] val);
    int                r;
    logic signed [5:0] v;
    r = int'(idx[lic_pkg::CFG_IDX_W-1:1]);
    v = signed'(val);
    if (r >= ROUTES) return;
    if (idx[0] == REG_SEL_CPU) begin
      route_cpu[r] = v;
      if (v >= 0) cpu_enable[v[4:0]] = 1'b1;
    end else begin
      route_line[r] = v;
    end
  endfunction

  // Update state for one request and queue the events it produces
  function automatic void predict_events(input logic [2:0] op, input logic [4:0] ln,
                                         input logic [31:0] raw);
    logic [31:0]       bit_ln;
    logic signed [5:0] ci;
    logic signed [5:0] inj;
    logic [31:0]       pend;
    logic [31:0]       served;
    logic [31:0]       b;
    lic_pkg::event_t   found[$];
    lic_pkg::event_t   ev;
    bit_ln = 32'd1 << ln;
    case (op)
      lic_pkg::OP_MASK: begin
        line_masked |= bit_ln;
        ci = routed_cpu(ln);
        if (ci >= 0) cpu_enable[ci[4:0]] = 1'b0;
      end
      lic_pkg::OP_UNMASK: begin
        line_masked &= ~bit_ln;
        ci = routed_cpu(ln);
        if (ci >= 0) cpu_enable[ci[4:0]] = 1'b1;
        if ((line_pending & bit_ln) != 0) begin
          line_pending &= ~bit_ln;
          ring_doorbell(ln);
        end
      end
      lic_pkg::OP_INJECT: begin
        if ((line_masked & bit_ln) != 0) line_pending |= bit_ln;
        else ring_doorbell(ln);
      end
      lic_pkg::OP_CLEAR: line_pending &= ~bit_ln;
      lic_pkg::OP_DISPATCH: begin
        // Sample the serviceable set once
        pend = (raw | ({31'd0, doorbell} << lic_pkg::DOORBELL_INT)) & cpu_enable &
               lic_pkg::L1_MASK;
        served = '0;
        if (pend[lic_pkg::TIMER_INT]) begin
          cpu_enable[lic_pkg::TIMER_INT] = 1'b0;
          ev = '{kind: lic_pkg::KIND_TIMER, number: lic_pkg::TIMER_INT, last: 1'b0};
          found.push_back(ev);
        end
        if (pend[lic_pkg::DOORBELL_INT]) begin
          inj                               = injected;
          doorbell                          = 1'b0;
          cpu_enable[lic_pkg::DOORBELL_INT] = 1'b0;
          injected                          = -6'sd1;
          if (inj >= 0) begin
            ev = '{kind: lic_pkg::KIND_LINE, number: inj[4:0], last: 1'b0};
            found.push_back(ev);
          end
        end
        for (int r = 0; r < ROUTES; r++) begin
          if (route_cpu[r] >= 0) begin
            b = 32'd1 << route_cpu[r][4:0];
            if ((pend & b) != 0 && (served & b) == 0) begin
              served |= b;
              ev = '{kind: lic_pkg::KIND_DEVICE, number: route_cpu[r][4:0], last: 1'b0};
              found.push_back(ev);
            end
          end
        end
        if (found.size() == 0) begin
          ev = '{kind: lic_pkg::KIND_NONE, number: 5'd0, last: 1'b0};
          found.push_back(ev);
        end
        found[found.size()-1].last = 1'b1;
        foreach (found[i]) expected_events.push_back(found[i]);
      end
      lic_pkg::OP_TMR_EN:  cpu_enable[lic_pkg::TIMER_INT] = 1'b1;
      lic_pkg::OP_TMR_DIS: cpu_enable[lic_pkg::TIMER_INT] = 1'b0;
      default: ;
    endcase
  endfunction

  // Offer one request, with random idle cycles ahead of it, until accepted
  task automatic send_req(input logic [2:0] op, input logic [4:0] ln,
                          input logic [31:0] raw);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_line       <= ln;
    in_raw_status <= raw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_events(op, ln, raw);
  endtask

  // Drop valid and hold until every queued event has come out
  task automatic wait_idle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (expected_events.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [lic_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lic_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_route_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic set_route(input int r, input int cpu, input int ln);
    cfg_write({r[1:0], REG_SEL_CPU}, cpu[lic_pkg::CFG_W-1:0]);
    cfg_write({r[1:0], REG_SEL_LINE}, ln[lic_pkg::CFG_W-1:0]);
  endtask

  // Draw a request biased toward routed lines and dispatches
  task automatic send_random_req();
    int          pick;
    logic [2:0]  op;
    logic [4:0]  ln;
    logic [31:0] raw;
    pick = $urandom_range(0, 99);
    if (pick < 30)      op = lic_pkg::OP_DISPATCH;
    else if (pick < 46) op = lic_pkg::OP_INJECT;
    else if (pick < 60) op = lic_pkg::OP_UNMASK;
    else if (pick < 72) op = lic_pkg::OP_MASK;
    else if (pick < 80) op = lic_pkg::OP_CLEAR;
    else if (pick < 88) op = lic_pkg::OP_TMR_EN;
    else if (pick < 96) op = lic_pkg::OP_TMR_DIS;
    else                op = OP_RESERVED;
    if ($urandom_range(0, 1) != 0) ln = 5'($urandom_range(0, 7));
    else                           ln = 5'($urandom);
    case ($urandom_range(0, 3))
      0:       raw = '1;
      1:       raw = '0;
      default: raw = $urandom;
    endcase
    send_req(op, ln, raw);
  endtask

  // Rebind every route, mostly to serviceable interrupts and low lines
  task automatic randomize_routes();
    int cpu;
    int ln;
    for (int r = 0; r < ROUTES; r++) begin
      case ($urandom_range(0, 5))
        0:       cpu = -1;
        1:       cpu = $urandom_range(6, 7);
        2:       cpu = $urandom_range(0, 63);
        default: cpu = $urandom_range(0, 18);
      endcase
      if ($urandom_range(0, 3) == 0) ln = $urandom_range(0, 63);
      else                           ln = $urandom_range(0, 7);
      set_route(r, cpu, ln);
    end
  endtask

  // Receiver: random stall, or a long hold-off when requested
  initial begin : stall_driver
    int k;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        for (k = 0; k < hold_len; k++) @(posedge clk);
        hold_req = 1'b0;
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Compare each accepted event with the oldest expected one
  always @(posedge clk) begin : check_events
    lic_pkg::event_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_events.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected event: kind=%0d number=%0d last=%0d",
                   out_event_kind, out_event_number, out_last);
        mismatches++;
      end else begin
        want = expected_events.pop_front();
        if (out_event_kind !== want.kind || out_event_number !== want.number ||
            out_last !== want.last) begin
          if (mismatches < MAX_REPORTS)
            $display("event mismatch: expected kind=%0d number=%0d last=%0d, got %0d %0d %0d",
                     want.kind, want.number, want.last,
                     out_event_kind, out_event_number, out_last);
          mismatches++;
        end
      end
    end
  end

  // Reset state, timer and doorbell paths, routes on six and seven, shared line
  task automatic test_directed();
    send_req(lic_pkg::OP_DISPATCH, 5'd0, '1);
    send_req(OP_RESERVED, 5'd31, '1);
    send_req(lic_pkg::OP_TMR_EN, 5'd0, '0);
    send_req(lic_pkg::OP_DISPATCH, 5'd0, '1);
    send_req(lic_pkg::OP_DISPATCH, 5'd31, '1);
    send_req(lic_pkg::OP_INJECT, 5'd31, '0);
    send_req(lic_pkg::OP_UNMASK, 5'd31, '0);
    send_req(lic_pkg::OP_DISPATCH, 5'd0, '0);
    send_req(lic_pkg::OP_DISPATCH, 5'd0, 32'h0000_0080);
    wait_idle();
    set_route(0, 17, 0);
    set_route(1, 6, 31);
    set_route(2, 7, 5);
    set_route(3, 18, 0);
    send_req(lic_pkg::OP_DISPATCH, 5'd0, '1);
    send_req(lic_pkg::OP_MASK, 5'd0, '0);
    send_req(lic_pkg::OP_DISPATCH, 5'd0, '1);
    send_req(lic_pkg::OP_UNMASK, 5'd0, '0);
    send_req(lic_pkg::OP_INJECT, 5'd0, '0);
    send_req(lic_pkg::OP_TMR_EN, 5'd0, '0);
    send_req(lic_pkg::OP_UNMASK, 5'd31, '0);
    send_req(lic_pkg::OP_UNMASK, 5'd5, '0);
    send_req(lic_pkg::OP_DISPATCH, 5'd0, '1);
    send_req(lic_pkg::OP_MASK, 5'd5, '0);
    send_req(lic_pkg::OP_INJECT, 5'd5, '0);
    send_req(lic_pkg::OP_CLEAR, 5'd5, '0);
    send_req(lic_pkg::OP_UNMASK, 5'd5, '0);
    send_req(lic_pkg::OP_DISPATCH, 5'd0, '0);
    send_req(lic_pkg::OP_DISPATCH, 5'd0, 32'h0000_0080);
    send_req(lic_pkg::OP_MASK, 5'd31, '0);
    send_req(lic_pkg::OP_TMR_DIS, 5'd0, '0);
    send_req(lic_pkg::OP_DISPATCH, 5'd0, '1);
    wait_idle();
  endtask

  // Extreme register values; unbound first route on a shared line
  task automatic test_route_extremes();
    set_route(0, -32, 3);
    set_route(1, 31, 3);
    set_route(2, 0, -1);
    set_route(3, -1, 31);
    send_req(lic_pkg::OP_MASK, 5'd3, '0);
    send_req(lic_pkg::OP_UNMASK, 5'd3, '0);
    send_req(lic_pkg::OP_INJECT, 5'd3, '0);
    send_req(lic_pkg::OP_UNMASK, 5'd31, '0);
    send_req(lic_pkg::OP_DISPATCH, 5'd0, '1);
    send_req(lic_pkg::OP_MASK, 5'd31, '0);
    send_req(lic_pkg::OP_DISPATCH, 5'd0, 32'h8000_0001);
    wait_idle();
    set_route(0, 0, -32);
    set_route(3, 31, 0);
    send_req(lic_pkg::OP_UNMASK, 5'd0, '0);
    send_req(lic_pkg::OP_DISPATCH, 5'd0, '1);
    wait_idle();
  endtask

  // Random requests across the idle and stall mixes
  task automatic test_random_traffic();
    int sender_mix [4];
    int stall_mix [4];
    sender_mix = '{0, 87, 0, 35};
    stall_mix  = '{0, 0, 87, 35};
    for (int p = 0; p < 4; p++) begin
      randomize_routes();
      send_idle_pct = sender_mix[p];
      stall_pct     = stall_mix[p];
      for (int n = 0; n < 20; n++) send_random_req();
      wait_idle();
    end
    send_idle_pct = 0;
    stall_pct     = 0;
  endtask

  // Hold the receiver off long enough to fill the block, keep offering
  task automatic test_backpressure();
    set_route(0, 17, 1);
    set_route(1, 18, 2);
    set_route(2, 6, 3);
    set_route(3, 7, 4);
    send_req(lic_pkg::OP_UNMASK, 5'd1, '0);
    hold_len = 300;
    hold_req = 1'b1;
    for (int n = 0; n < 30; n++) begin
      if (n % 3 == 0) send_req(lic_pkg::OP_INJECT, 5'd1, '0);
      else if (n % 3 == 1) send_req(lic_pkg::OP_TMR_EN, 5'd0, '0);
      else send_req(lic_pkg::OP_DISPATCH, 5'd0, '1);
    end
    while (hold_req) @(posedge clk);
    wait_idle();
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_operation  = lic_pkg::OP_MASK;
    in_line       = '0;
    in_raw_status = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    mismatches    = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_len      = 0;
    hold_req      = 1'b0;
    reset_state();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_route_extremes();
    test_random_traffic();
    test_backpressure();
    if (mismatches == 0 && expected_events.size() == 0)
      $display("logical_interrupt_controller: match");
    else
      $display("logical_interrupt_controller: mismatch");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("logical_interrupt_controller: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/lic_pkg.sv
sv/lic_core.sv
sv/lic_evq.sv
sv/logical_interrupt_controller.sv
tb/tb_top.sv
